// ===== rtl/button_press_classifier_led_blinker_unit_defines.svh =====
// Assertion macros used by the RTL file that checks its own logic.
`ifndef BUTTON_PRESS_CLASSIFIER_LED_BLINKER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_LED_BLINKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

  // Item codes carried in the action field.
  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_LED_SET     = 3'd1,
    ACT_LED_CLEAR   = 3'd2,
    ACT_LED_TOGGLE  = 3'd3,
    ACT_BLINK_START = 3'd4,
    ACT_BLINK_STOP  = 3'd5
  } action_t;

  // Press classes reported on the result channel.
  localparam logic [1:0] CLS_RELEASED = 2'd0;
  localparam logic [1:0] CLS_SHORT    = 2'd1;
  localparam logic [1:0] CLS_LONG     = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_SAMPLE_PERIOD = 1'b0;
  localparam logic CFG_LONG_PRESS    = 1'b1;

  localparam int CFG_DATA_W = 16;

  // Register reset values and the press timer limit.
  localparam logic [9:0]  SAMPLE_PERIOD_RST = 10'd25;
  localparam logic [15:0] LONG_PRESS_RST    = 16'd2000;
  localparam logic [15:0] PRESS_TICKS_MAX   = 16'hFFFF;

  // One input transaction as held in the input register.
  typedef struct packed {
    action_t     action;
    logic        button_level;
    logic [31:0] blink_ms;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic       led_level;
    logic [1:0] press_class;
  } out_item_t;

  // Step request from the pipeline control to the state logic.
  typedef struct packed {
    logic     step;
    in_item_t item;
  } step_req_t;

endpackage

`default_nettype wire

// ===== rtl/bpc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one tick or LED command per transaction.
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        button_level;
  logic [31:0] blink_ms;

  modport source (output valid, output action, output button_level, output blink_ms,
                  input ready);
  modport sink (input valid, input action, input button_level, input blink_ms,
                output ready);
endinterface

// Result channel: LED level and press class after each item.
interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic       led_level;
  logic [1:0] press_class;

  modport source (output valid, output led_level, output press_class, input ready);
  modport sink (input valid, input led_level, input press_class, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpc_core
  import bpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire step_req_t             req,
  output out_item_t                  result
);

  // Configuration registers.
  logic [9:0]  sample_period_r;
  logic [15:0] long_press_r;

  // Block state.
  logic [9:0]  sample_phase_r, sample_phase_nxt;
  logic        prev_level_r, prev_level_nxt;
  logic [1:0]  class_r, class_nxt;
  logic [15:0] press_ticks_r, press_ticks_nxt;
  logic        led_r, led_nxt;
  logic        blink_on_r, blink_on_nxt;
  logic [30:0] half_period_r, half_period_nxt;
  logic [30:0] blink_phase_r, blink_phase_nxt;

  logic [9:0]  s_period;
  logic [10:0] s_next;
  logic        s_wrap;
  logic [15:0] press_inc;
  logic [30:0] b_period;
  logic [31:0] b_next;
  logic        b_wrap;

  // Divider arithmetic; a zero period behaves as a period of one.
  always_comb begin
    s_period  = (sample_period_r == 10'd0) ? 10'd1 : sample_period_r;
    s_next    = {1'b0, sample_phase_r} + 11'd1;
    s_wrap    = (s_next >= {1'b0, s_period});
    b_period  = (half_period_r == 31'd0) ? 31'd1 : half_period_r;
    b_next    = {1'b0, blink_phase_r} + 32'd1;
    b_wrap    = (b_next >= {1'b0, b_period});
    press_inc = (press_ticks_r < PRESS_TICKS_MAX) ? press_ticks_r + 16'd1 : press_ticks_r;
  end

  // Next state for the item held in the input register.
  always_comb begin
    sample_phase_nxt = sample_phase_r;
    prev_level_nxt   = prev_level_r;
    class_nxt        = class_r;
    press_ticks_nxt  = press_ticks_r;
    led_nxt          = led_r;
    blink_on_nxt     = blink_on_r;
    half_period_nxt  = half_period_r;
    blink_phase_nxt  = blink_phase_r;
    case (req.item.action)
      ACT_TICK: begin
        press_ticks_nxt  = press_inc;
        sample_phase_nxt = s_wrap ? 10'd0 : s_next[9:0];
        // The button is sampled when the sample divider wraps.
        if (s_wrap) begin
          prev_level_nxt = req.item.button_level;
          if (req.item.button_level == prev_level_r) begin
            if (req.item.button_level) begin
              class_nxt       = CLS_RELEASED;
              press_ticks_nxt = 16'd0;
            end else begin
              class_nxt = (press_inc >= long_press_r) ? CLS_LONG : CLS_SHORT;
            end
          end
        end
        blink_phase_nxt = b_wrap ? 31'd0 : b_next[30:0];
        if (b_wrap && blink_on_r) begin
          led_nxt = ~led_r;
        end
      end
      ACT_LED_SET: begin
        blink_on_nxt = 1'b0;
        led_nxt      = 1'b1;
      end
      ACT_LED_CLEAR: begin
        blink_on_nxt = 1'b0;
        led_nxt      = 1'b0;
      end
      ACT_LED_TOGGLE: begin
        blink_on_nxt = 1'b0;
        led_nxt      = ~led_r;
      end
      ACT_BLINK_START: begin
        blink_phase_nxt = 31'd0;
        half_period_nxt = (req.item.blink_ms[31:1] == 31'd0) ? 31'd1
                                                             : req.item.blink_ms[31:1];
        blink_on_nxt    = 1'b1;
      end
      ACT_BLINK_STOP: begin
        blink_on_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_phase_r <= 10'd0;
      prev_level_r   <= 1'b0;
      class_r        <= CLS_RELEASED;
      press_ticks_r  <= 16'd0;
      led_r          <= 1'b0;
      blink_on_r     <= 1'b0;
      half_period_r  <= 31'd1;
      blink_phase_r  <= 31'd0;
    end else if (req.step) begin
      sample_phase_r <= sample_phase_nxt;
      prev_level_r   <= prev_level_nxt;
      class_r        <= class_nxt;
      press_ticks_r  <= press_ticks_nxt;
      led_r          <= led_nxt;
      blink_on_r     <= blink_on_nxt;
      half_period_r  <= half_period_nxt;
      blink_phase_r  <= blink_phase_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= SAMPLE_PERIOD_RST;
      long_press_r    <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_PERIOD: sample_period_r <= cfg_data[9:0];
        CFG_LONG_PRESS:    long_press_r    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign result.led_level   = led_nxt;
  assign result.press_class = class_nxt;

endmodule

`default_nettype wire

// ===== rtl/button_press_classifier_led_blinker_unit.sv =====
// Throughput: one item per cycle while the result channel does not stall; the input
// register feeds the state update logic, which loads the result register, and both
// registers advance together. Reset: synchronous, active low; clears the valid flags
// of both channel registers, restores the configuration registers to their defaults
// and the block state to its reset values.
`timescale 1ns / 1ps
`default_nettype none
`include "button_press_classifier_led_blinker_unit_defines.svh"

module button_press_classifier_led_blinker_unit
  import bpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bpc_in_if.sink                     in_ch,
  bpc_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_r;
  logic      out_valid_r;
  logic      adv;
  step_req_t req;
  out_item_t result;

  // The held item moves on when the result register is free or being drained.
  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign req.step     = adv;
  assign req.item     = in_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r.action       <= action_t'(in_ch.action);
      in_r.button_level <= in_ch.button_level;
      in_r.blink_ms     <= in_ch.blink_ms;
    end
  end

  bpc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .result    (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= result;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.led_level   = out_r.led_level;
  assign out_ch.press_class = out_r.press_class;

  // A processed item always produces a result transaction.
  `BPC_ASSERT_NEXT(a_adv_gives_result, adv, out_valid_r, "processed item lost its result")
  // A held item that cannot move on stays held.
  `BPC_ASSERT_NEXT(a_hold_item, in_valid_r && !adv, in_valid_r, "held input item dropped")
  // An LED set command always reports the LED on.
  `BPC_ASSERT_NEXT(a_led_set, adv && (in_r.action == ACT_LED_SET), out_r.led_level,
                   "LED set did not light the LED")
  // Only defined press classes leave the block.
  `BPC_ASSERT_IMPL(a_class_code, out_valid_r,
                   (out_r.press_class == CLS_RELEASED) || (out_r.press_class == CLS_SHORT) ||
                   (out_r.press_class == CLS_LONG), "undefined press class")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bpc_pkg::*;

  // Action codes the package leaves unnamed; the block must ignore them.
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int SOAK_TICKS     = 24;

  // Tracks the classifier and blinker state and holds the LED/class pairs still due.
  class press_led_scoreboard;
    logic [9:0]  smp_period;
    logic [15:0] long_limit;
    logic [9:0]  smp_phase;
    logic        prev_lvl;
    logic [1:0]  press_cls;
    logic [15:0] held_ticks;
    logic        led;
    logic        blinking;
    logic [30:0] half_per;
    logic [30:0] blink_ph;
    out_item_t   led_class_due[$];
    int          errors;
    int          items_in;
    int          results_ok;
    int          reg_writes;
    int          n_short;
    int          n_long;
    int          n_blinks;

    function new();
      smp_period = SAMPLE_PERIOD_RST;
      long_limit = LONG_PRESS_RST;
      smp_phase  = '0;
      prev_lvl   = 1'b0;
      press_cls  = CLS_RELEASED;
      held_ticks = '0;
      led        = 1'b0;
      blinking   = 1'b0;
      half_per   = 31'd1;
      blink_ph   = '0;
      errors     = 0;
      items_in   = 0;
      results_ok = 0;
      reg_writes = 0;
      n_short    = 0;
      n_long     = 0;
      n_blinks   = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      reg_writes++;
      if (idx == CFG_SAMPLE_PERIOD) smp_period = data[9:0];
      else long_limit = data;
    endfunction

    // One millisecond tick: press timer, button sampler, then blink divider.
    function void tick(logic lvl);
      logic [9:0]  sp;
      logic [10:0] nxt_s;
      logic [30:0] hp;
      logic [31:0] nxt_b;
      if (held_ticks != PRESS_TICKS_MAX) held_ticks = held_ticks + 16'd1;

      sp    = (smp_period == '0) ? 10'd1 : smp_period;
      nxt_s = {1'b0, smp_phase} + 11'd1;
      smp_phase = (nxt_s >= {1'b0, sp}) ? 10'd0 : nxt_s[9:0];
      if (smp_phase == '0) begin
        if (lvl == prev_lvl) begin
          if (lvl) begin
            press_cls  = CLS_RELEASED;
            held_ticks = '0;
          end else begin
            press_cls = (held_ticks >= long_limit) ? CLS_LONG : CLS_SHORT;
          end
        end
        prev_lvl = lvl;
      end

      hp    = (half_per == '0) ? 31'd1 : half_per;
      nxt_b = {1'b0, blink_ph} + 32'd1;
      blink_ph = (nxt_b >= {1'b0, hp}) ? 31'd0 : nxt_b[30:0];
      if (blink_ph == '0 && blinking) begin
        led = ~led;
        n_blinks++;
      end
    endfunction

    // Applies one accepted input transaction and queues the result it causes.
    function void note_item(logic [2:0] act, logic lvl, logic [31:0] ms);
      out_item_t due;
      items_in++;
      case (act)
        ACT_TICK: tick(lvl);
        ACT_LED_SET: begin
          blinking = 1'b0;
          led      = 1'b1;
        end
        ACT_LED_CLEAR: begin
          blinking = 1'b0;
          led      = 1'b0;
        end
        ACT_LED_TOGGLE: begin
          blinking = 1'b0;
          led      = ~led;
        end
        ACT_BLINK_START: begin
          blink_ph = '0;
          half_per = ms[31:1];
          if (half_per == '0) half_per = 31'd1;
          blinking = 1'b1;
        end
        ACT_BLINK_STOP: blinking = 1'b0;
        default: ;
      endcase
      if (act == ACT_TICK && press_cls == CLS_SHORT) n_short++;
      if (act == ACT_TICK && press_cls == CLS_LONG) n_long++;
      due.led_level   = led;
      due.press_class = press_cls;
      led_class_due.push_back(due);
    endfunction

    // Compares one accepted result transaction with the oldest one due.
    function void check_result(out_item_t got);
      out_item_t want;
      if (led_class_due.size() == 0) begin
        $error("result transaction with none due: led_level %0d, press_class %0d",
               got.led_level, got.press_class);
        errors++;
        return;
      end
      want = led_class_due.pop_front();
      if (got.led_level !== want.led_level) begin
        $error("led_level: expected %0d, actual %0d", want.led_level, got.led_level);
        errors++;
      end
      if (got.press_class !== want.press_class) begin
        $error("press_class: expected %0d, actual %0d", want.press_class, got.press_class);
        errors++;
      end
      if (got.led_level === want.led_level && got.press_class === want.press_class)
        results_ok++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  bit          quiet;
  int          sp_cur;
  int          lp_cur;
  int          idle_cycles;
  press_led_scoreboard sb;

  bpc_in_if  in_ch ();
  bpc_out_if out_ch ();

  button_press_classifier_led_blinker_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 11);
  end

  // Watch both channels and the register port at each edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.action, in_ch.button_level, in_ch.blink_ms);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.led_level, out_ch.press_class});
    end
  end

  // End the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles.", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one input transaction and waits until it is accepted.
  task automatic send_item(logic [2:0] act, logic lvl, logic [31:0] ms);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 11) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.button_level <= lvl;
    in_ch.blink_ms     <= ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_SAMPLE_PERIOD) sp_cur = data;
    else lp_cur = data;
  endtask

  // Drains the block so that registers can be written safely.
  // The first edge lets the monitor record the last accepted transaction.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.led_class_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random LED command, now and then a reserved code.
  task automatic rand_command();
    int          r;
    logic [2:0]  act;
    logic [31:0] ms;
    r = $urandom_range(0, 99);
    if (r < 18) act = ACT_LED_SET;
    else if (r < 36) act = ACT_LED_CLEAR;
    else if (r < 54) act = ACT_LED_TOGGLE;
    else if (r < 78) act = ACT_BLINK_START;
    else if (r < 94) act = ACT_BLINK_STOP;
    else if (r < 97) act = ACT_SPARE_6;
    else act = ACT_SPARE_7;
    ms = $urandom();
    if (act == ACT_BLINK_START && $urandom_range(0, 3) != 0) ms = $urandom_range(0, 40);
    send_item(act, 1'($urandom_range(0, 1)), ms);
  endtask

  // Press and release stretches with commands mixed in, plus some bouncing noise.
  task automatic run_presses(int n);
    int   sent;
    int   hold;
    int   hmax;
    int   sp_eff;
    int   k;
    logic lvl;
    sent = 0;
    lvl  = 1'b1;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 80) begin
        lvl    = ~lvl;
        sp_eff = (sp_cur == 0) ? 1 : sp_cur;
        hmax   = 2 * sp_eff + 2 * lp_cur + 4;
        if (hmax > 120) hmax = 120;
        hold = $urandom_range(1, hmax);
        for (k = 0; k < hold && sent < n; k++) begin
          if ($urandom_range(0, 99) < 15) begin
            rand_command();
            sent++;
          end
          send_item(ACT_TICK, ($urandom_range(0, 99) < 5) ? ~lvl : lvl, $urandom());
          sent++;
        end
      end else begin
        hold = $urandom_range(1, 6);
        for (k = 0; k < hold; k++) begin
          send_item(ACT_TICK, 1'($urandom_range(0, 1)), $urandom());
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(int sp, int lp, int n, bit no_gaps);
    settle();
    write_reg(CFG_SAMPLE_PERIOD, 16'(sp));
    write_reg(CFG_LONG_PRESS, 16'(lp));
    quiet = no_gaps;
    run_presses(n);
  endtask

  initial begin
    int i;
    sb = new();
    quiet  = 1'b0;
    sp_cur = SAMPLE_PERIOD_RST;
    lp_cur = LONG_PRESS_RST;
    rst_n  <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SAMPLE_PERIOD;
    cfg_data  <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_TICK;
    in_ch.button_level <= 1'b1;
    in_ch.blink_ms     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset values, then short, long and release with fast sampling.
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_TICK, 1'b0, 32'hFFFF_FFFF);
    settle();
    write_reg(CFG_SAMPLE_PERIOD, 16'd1);
    write_reg(CFG_LONG_PRESS, 16'd4);
    send_item(ACT_TICK, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_TICK, 1'b0, 32'h0);
    send_item(ACT_TICK, 1'b1, 32'h0);
    // LED commands, blinking with a repaired half period, and the period extremes.
    send_item(ACT_LED_SET, 1'b0, 32'hFFFF_FFFF);
    send_item(ACT_LED_CLEAR, 1'b1, 32'hFFFF_FFFF);
    send_item(ACT_LED_TOGGLE, 1'b0, 32'h0);
    send_item(ACT_BLINK_START, 1'b1, 32'd0);
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_BLINK_START, 1'b0, 32'd1);
    send_item(ACT_BLINK_START, 1'b0, 32'd5);
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_LED_TOGGLE, 1'b1, 32'h0);
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_BLINK_START, 1'b1, 32'hFFFF_FFFF);
    send_item(ACT_TICK, 1'b1, 32'h0);
    send_item(ACT_BLINK_STOP, 1'b0, 32'h0);
    send_item(ACT_SPARE_6, 1'b1, 32'hFFFF_FFFF);
    send_item(ACT_SPARE_7, 1'b0, 32'h0);

    // Random phases over several register settings, one of them without gaps.
    run_phase(1, 1, 140, 1'b0);
    run_phase(3, 10, 140, 1'b0);
    run_phase(0, 0, 140, 1'b0);
    run_phase(7, 40, 140, 1'b0);
    run_phase(2, 25, 160, 1'b1);
    run_phase(1000, 65535, 140, 1'b0);
    run_phase(5, 3, 140, 1'b0);
    run_phase($urandom_range(1, 8), $urandom_range(1, 50), 140, 1'b0);

    // Hold the button down past the long-press threshold.
    settle();
    write_reg(CFG_SAMPLE_PERIOD, 16'd1);
    write_reg(CFG_LONG_PRESS, 16'd16);
    quiet = 1'b0;
    for (i = 0; i < SOAK_TICKS; i++) send_item(ACT_TICK, 1'b0, $urandom());

    settle();
    $display("Covered %0d input transactions, %0d results matched, %0d register writes.",
             sb.items_in, sb.results_ok, sb.reg_writes);
    $display("Ticks ending short %0d, long %0d; blink toggles %0d.",
             sb.n_short, sb.n_long, sb.n_blinks);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_if.sv
rtl/bpc_core.sv
rtl/button_press_classifier_led_blinker_unit.sv
tb/tb.sv
